// ----- rtl/core/pairwise_average_clustering_unit_macros.svh -----
// assertion macros for the pairwise average clustering unit
// used by the top level; no other dependencies
`ifndef PAIRWISE_AVERAGE_CLUSTERING_UNIT_MACROS_SVH
`define PAIRWISE_AVERAGE_CLUSTERING_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define PACU_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define PACU_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PACU_ASSERT(name, clk, rst, prop, msg)
`define PACU_ASSERT_ALWAYS(name, clk, prop, msg)
`endif
`endif

// ----- rtl/core/pacu_pkg.sv -----
// types and constants of the pairwise average clustering unit
// no dependencies
`timescale 1ns / 1ps
package pacu_pkg;

  localparam int unsigned TAXA_MIN = 3;
  localparam int unsigned COUNT_BITS = 5;

  typedef struct packed {
    logic [3:0]  row_index;
    logic [3:0]  col_index;
    logic [15:0] similarity_value;
    logic        last_entry;
  } load_item_t;

  typedef struct packed {
    logic [4:0]  first_node;
    logic [4:0]  second_node;
    logic [15:0] merge_similarity;
    logic        last_merge;
  } merge_result_t;

endpackage

// ----- rtl/core/pacu_sim_ram.sv -----
// similarity store: one write port, one read port, registered read data
// no dependencies
`timescale 1ns / 1ps
module pacu_sim_ram #(
  parameter int AW = 8,
  parameter int DW = 16
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/pairwise_average_clustering_unit.sv -----
// top level of the pairwise average clustering unit
// uses pacu_pkg, pacu_sim_ram and the assertion macro header
`timescale 1ns / 1ps
`include "pairwise_average_clustering_unit_macros.svh"

// Loads a symmetric similarity matrix one entry per start pulse (the entry is written at
// [row][col] and [col][row]); an entry with last_entry set then runs
// the whole clustering and emits n-1 merges, each on result for one cycle marked by
// result_valid. The receiver cannot stall: results must be taken as they appear. busy
// stays high for the whole run. The similarity store has a single read port: the
// pair scan reads one entry per cycle within a row, and the averaging pass reads two
// and writes two entries per surviving cluster.
module pairwise_average_clustering_unit
  import pacu_pkg::*;
#(
  parameter int MAX_TAXA   = 16,
  parameter int VALUE_BITS = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  load_item_t    item,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [COUNT_BITS-1:0] cfg_data,
  output logic          result_valid,
  output merge_result_t result
);

  localparam int IW = $clog2(MAX_TAXA);
  localparam int KW = $clog2(MAX_TAXA + 1);
  localparam int NW = $clog2(2 * MAX_TAXA);
  localparam int AW = 2 * IW;

  typedef enum logic [12:0] {
    S_IDLE    = 13'b0000000000001,
    S_LOAD2   = 13'b0000000000010,
    S_INIT    = 13'b0000000000100,
    S_SCAN_X  = 13'b0000000001000,
    S_SCAN_Y  = 13'b0000000010000,
    S_SCAN_END= 13'b0000000100000,
    S_EMIT    = 13'b0000001000000,
    S_UPD_X   = 13'b0000010000000,
    S_UPD_RA  = 13'b0000100000000,
    S_UPD_RB  = 13'b0001000000000,
    S_UPD_WB  = 13'b0010000000000,
    S_UPD_WT  = 13'b0100000000000,
    S_COMPACT = 13'b1000000000000
  } state_t;

  state_t state;

  logic [COUNT_BITS-1:0] taxa_count;
  logic [KW-1:0] k;
  logic [KW-1:0] x;
  logic [IW-1:0] y;
  logic [NW-1:0] next_node_id;

  // clusters in order: slot and node id of each position
  logic [IW-1:0] pos_slot [MAX_TAXA];
  logic [NW-1:0] pos_node [MAX_TAXA];
  logic [IW-1:0] pos_addr;
  logic [IW-1:0] pos_slot_rd;
  logic [NW-1:0] pos_node_rd;

  logic [IW-1:0] ox_slot;
  logic [NW-1:0] ox_node;
  logic [IW-1:0] t_slot;

  // scan tags traveling with the store read
  logic          rd_valid;
  logic [KW-1:0] tag_x;
  logic [IW-1:0] tag_y;
  logic [IW-1:0] tag_a;
  logic [IW-1:0] tag_b;
  logic [NW-1:0] tag_an;
  logic [NW-1:0] tag_bn;

  logic                  first_cmp;
  logic [VALUE_BITS-1:0] best_v;
  logic [KW-1:0]         best_x;
  logic [IW-1:0]         best_y;
  logic [IW-1:0]         best_a;
  logic [IW-1:0]         best_b;
  logic [NW-1:0]         best_an;
  logic [NW-1:0]         best_bn;

  logic [VALUE_BITS-1:0] va;
  logic [VALUE_BITS-1:0] mean_q;
  logic [VALUE_BITS:0]   sum;
  logic [VALUE_BITS-1:0] mean;

  // saved load entry for the mirrored write
  logic [IW-1:0]         ld_row;
  logic [IW-1:0]         ld_col;
  logic [VALUE_BITS-1:0] ld_val;
  logic                  ld_ok;
  logic                  ld_last;

  logic                  we;
  logic [AW-1:0]         waddr;
  logic [VALUE_BITS-1:0] wdata;
  logic [AW-1:0]         raddr;
  logic [VALUE_BITS-1:0] rdata;

  logic                  accept;
  logic                  in_ok;
  logic [VALUE_BITS-1:0] in_val;
  logic [31:0]           in_val32;
  logic [KW-1:0]         n_eff;
  logic [31:0]           best_v32;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign in_ok     = (32'(item.row_index) < 32'(MAX_TAXA)) &&
                     (32'(item.col_index) < 32'(MAX_TAXA));
  assign in_val32  = 32'(item.similarity_value);
  assign in_val    = in_val32[VALUE_BITS-1:0];
  assign best_v32  = 32'(best_v);

  // clamp of the taxa count
  always_comb begin
    if (32'(taxa_count) < TAXA_MIN) begin
      n_eff = KW'(TAXA_MIN);
    end else if (32'(taxa_count) > 32'(MAX_TAXA)) begin
      n_eff = KW'(MAX_TAXA);
    end else begin
      n_eff = KW'(taxa_count);
    end
  end

  // one position read per cycle
  assign pos_addr    = (state == S_SCAN_Y) ? y : x[IW-1:0];
  assign pos_slot_rd = pos_slot[pos_addr];
  assign pos_node_rd = pos_node[pos_addr];

  assign sum  = {1'b0, va} + {1'b0, rdata};
  assign mean = sum[VALUE_BITS:1];

  // store read address
  always_comb begin
    case (state)
      S_SCAN_Y: raddr = {ox_slot, pos_slot_rd};
      S_UPD_RA: raddr = {best_a, t_slot};
      S_UPD_RB: raddr = {best_b, t_slot};
      default:  raddr = '0;
    endcase
  end

  // store write port
  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    case (state)
      S_IDLE: begin
        we    = accept && in_ok;
        waddr = {IW'(item.row_index), IW'(item.col_index)};
        wdata = in_val;
      end
      S_LOAD2: begin
        we    = ld_ok;
        waddr = {ld_col, ld_row};
        wdata = ld_val;
      end
      S_UPD_WB: begin
        we    = 1'b1;
        waddr = {best_b, t_slot};
        wdata = mean;
      end
      S_UPD_WT: begin
        we    = 1'b1;
        waddr = {t_slot, best_b};
        wdata = mean_q;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  pacu_sim_ram #(
    .AW(AW),
    .DW(VALUE_BITS)
  ) u_sim_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      taxa_count <= COUNT_BITS'(11);
    end else if (cfg_valid && cfg_ready) begin
      taxa_count <= cfg_data;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
      rd_valid     <= 1'b0;
      first_cmp    <= 1'b1;
      k            <= '0;
      x            <= '0;
      y            <= '0;
      next_node_id <= '0;
    end else begin
      result_valid <= (state == S_EMIT);
      rd_valid     <= (state == S_SCAN_Y);
      case (state)
        S_IDLE: begin
          if (accept) begin
            ld_row  <= IW'(item.row_index);
            ld_col  <= IW'(item.col_index);
            ld_val  <= in_val;
            ld_ok   <= in_ok;
            ld_last <= item.last_entry;
            state   <= S_LOAD2;
          end
        end
        S_LOAD2: begin
          state <= ld_last ? S_INIT : S_IDLE;
        end
        S_INIT: begin
          for (int i = 0; i < MAX_TAXA; i++) begin
            pos_slot[i] <= IW'(i);
            pos_node[i] <= NW'(i);
          end
          k            <= n_eff;
          next_node_id <= NW'(n_eff);
          x            <= KW'(1);
          first_cmp    <= 1'b1;
          state        <= S_SCAN_X;
        end
        S_SCAN_X: begin
          ox_slot <= pos_slot_rd;
          ox_node <= pos_node_rd;
          y       <= '0;
          state   <= S_SCAN_Y;
        end
        S_SCAN_Y: begin
          tag_x    <= x;
          tag_y    <= y;
          tag_a    <= ox_slot;
          tag_b    <= pos_slot_rd;
          tag_an   <= ox_node;
          tag_bn   <= pos_node_rd;
          if (KW'(y) + KW'(1) == x) begin
            if (x + KW'(1) == k) begin
              state <= S_SCAN_END;
            end else begin
              x     <= x + KW'(1);
              state <= S_SCAN_X;
            end
          end else begin
            y <= y + IW'(1);
          end
        end
        S_SCAN_END: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          result.first_node       <= 5'(best_an);
          result.second_node      <= 5'(best_bn);
          result.merge_similarity <= best_v32[15:0];
          result.last_merge       <= (k == KW'(2));
          x                       <= '0;
          state                   <= (k == KW'(2)) ? S_IDLE : S_UPD_X;
        end
        S_UPD_X: begin
          if (x == k) begin
            state <= S_COMPACT;
          end else if (x == best_x || x == KW'(best_y)) begin
            x <= x + KW'(1);
          end else begin
            t_slot <= pos_slot_rd;
            state  <= S_UPD_RA;
          end
        end
        S_UPD_RA: begin
          state <= S_UPD_RB;
        end
        S_UPD_RB: begin
          va    <= rdata;
          state <= S_UPD_WB;
        end
        S_UPD_WB: begin
          mean_q <= mean;
          state  <= S_UPD_WT;
        end
        S_UPD_WT: begin
          x     <= x + KW'(1);
          state <= S_UPD_X;
        end
        S_COMPACT: begin
          // drop both members, survivors close ranks, new cluster goes last
          for (int i = 0; i < MAX_TAXA; i++) begin
            if (KW'(i) == k - KW'(2)) begin
              pos_slot[i] <= best_b;
              pos_node[i] <= next_node_id;
            end else if (IW'(i) < best_y) begin
              pos_slot[i] <= pos_slot[i];
              pos_node[i] <= pos_node[i];
            end else if (KW'(i + 1) < best_x) begin
              if (i + 1 < MAX_TAXA) begin
                pos_slot[i] <= pos_slot[i + 1];
                pos_node[i] <= pos_node[i + 1];
              end
            end else if (i + 2 < MAX_TAXA) begin
              pos_slot[i] <= pos_slot[i + 2];
              pos_node[i] <= pos_node[i + 2];
            end
          end
          k            <= k - KW'(1);
          next_node_id <= next_node_id + NW'(1);
          x            <= KW'(1);
          first_cmp    <= 1'b1;
          state        <= S_SCAN_X;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      // running best pair, ties keep the earlier pair
      if (rd_valid && (first_cmp || rdata > best_v)) begin
        first_cmp <= 1'b0;
        best_v    <= rdata;
        best_x    <= tag_x;
        best_y    <= tag_y;
        best_a    <= tag_a;
        best_b    <= tag_b;
        best_an   <= tag_an;
        best_bn   <= tag_bn;
      end
    end
  end

  // checks
  `PACU_ASSERT(a_final_merge_idle, clk, rst, result_valid && result.last_merge |-> !busy, "final merge did not end the run")
  `PACU_ASSERT(a_read_from_scan, clk, rst, rd_valid |-> $past(state == S_SCAN_Y), "scan compare without a scan read")
  `PACU_ASSERT(a_scan_lower, clk, rst, (state == S_SCAN_Y) |-> (KW'(y) < x) && (x < k), "scan position out of triangle")
  `PACU_ASSERT(a_emit_single, clk, rst, result_valid |=> !result_valid, "result strobe held longer than a cycle")

endmodule
